// ===== rtl/flash_program_erase_controller_assert.svh =====
// Assertion macros for the checker file.
// Each use stands on a line of its own; clk and rst_n come from the scope.
`ifndef FLASH_PROGRAM_ERASE_CONTROLLER_ASSERT_SVH
`define FLASH_PROGRAM_ERASE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, muted while in reset.
`define FPEC_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("flash controller check failed");

// Next-cycle implication, muted while in reset.
`define FPEC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("flash controller check failed");

// Next-cycle implication that also holds through reset; reset loads the
// registers asynchronously.
`define FPEC_ASSERT_RAW(label, pre, post) \
    label: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("flash controller check failed");

`endif

// ===== rtl/fpec_pkg.sv =====
`timescale 1ns / 1ps

package fpec_pkg;

    // Bus operation codes, as carried by the func field.
    typedef enum logic [2:0] {
        OP_RD_SR   = 3'd0,
        OP_RD_CR   = 3'd1,
        OP_WR_SR   = 3'd2,
        OP_WR_CR   = 3'd3,
        OP_KEY     = 3'd4,
        OP_PROG    = 3'd5,
        OP_RD_WORD = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    localparam int WORD_IDX_W  = 18;
    localparam int QUEUE_DEPTH = 2;

    // Classified command handed from front to back.
    typedef struct packed {
        op_t                   op;
        logic                  aligned;
        logic                  key_one;
        logic                  key_two;
        logic [WORD_IDX_W-1:0] word;
        logic [31:0]           data;
    } cmd_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qhead_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_MEM   = 2'd2,
        S_ERASE = 2'd3
    } state_t;

    localparam logic [31:0] CTRL_RESET  = 32'hC000_0000;
    localparam logic [31:0] KEY_ONE     = 32'h4567_0123;
    localparam logic [31:0] KEY_TWO     = 32'hCDEF_89AB;
    localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;

    // Status bits.
    localparam int SR_EOP_BIT     = 0;
    localparam int SR_PROGERR_BIT = 3;
    localparam int SR_BSY_BIT     = 16;

    // Control bits.
    localparam int CR_PG_BIT   = 0;
    localparam int CR_PER_BIT  = 1;
    localparam int CR_MER1_BIT = 2;
    localparam int CR_PNB_LSB  = 3;
    localparam int CR_PNB_MSB  = 10;
    localparam int CR_BKER_BIT = 11;
    localparam int CR_MER2_BIT = 15;
    localparam int CR_STRT_BIT = 16;
    localparam int CR_LOCK_BIT = 31;

    // Register index on the configuration port (paddr bit 2).
    localparam logic REG_BANK_SWAP = 1'b0;

endpackage

// ===== rtl/flash_program_erase_controller.sv =====
`timescale 1ns / 1ps
// A beat is queued on acceptance; the back end pops it, runs it and registers its result;
// a flash word beat adds a step for the registered array read. The queue takes new beats meanwhile.
// Page erase walks PAGE_WORDS words before its result, mass erase every word of each bank chosen.
// Reset: control locked, status cleared, then a clearing pass over both banks
// writes every word erased while busy stays high; results cannot be stalled.

module flash_program_erase_controller #(
    parameter int BANK_ADDR_BITS = 17,
    parameter int PAGE_WORDS     = 512
) (
    input  logic        clk,
    input  logic        rst_n,

    // Command side: a beat is taken when start is high and busy is low.
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [19:0] addr,
    input  logic [31:0] data,

    // Result side: one beat per command, valid while done is high.
    output logic        done,
    output logic [31:0] read_data,
    output logic [31:0] status_now,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Front: classifies each beat and pushes it into the queue.
    // Queue: two entries, so the front keeps taking beats while the back works.
    // Back: owns the register state and the flash array; runs reads, programs
    // and the erase walks one word per cycle.

    fpec_pkg::cmd_t   f_cmd;
    fpec_pkg::qhead_t q_head;
    logic             f_push;
    logic             q_full;
    logic             b_pop;
    logic             b_clearing;
    logic             bank_swap_reg;

    assign pready = 1'b1;

    // Write the bank swap register on the access phase of an APB write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_swap_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr[2] == fpec_pkg::REG_BANK_SWAP))
        begin
            bank_swap_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == fpec_pkg::REG_BANK_SWAP) ? {31'd0, bank_swap_reg} : 32'd0;

    fpec_front u_front (
        .start    (start),
        .func     (func),
        .addr     (addr),
        .data     (data),
        .q_full   (q_full),
        .clearing (b_clearing),
        .busy     (busy),
        .push     (f_push),
        .cmd      (f_cmd)
    );

    fpec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .push_cmd (f_cmd),
        .pop      (b_pop),
        .full     (q_full),
        .head     (q_head)
    );

    fpec_back #(
        .BANK_ADDR_BITS (BANK_ADDR_BITS),
        .PAGE_WORDS     (PAGE_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .bank_swap  (bank_swap_reg),
        .head       (q_head),
        .pop        (b_pop),
        .clearing   (b_clearing),
        .done       (done),
        .read_data  (read_data),
        .status_now (status_now)
    );

endmodule

// ===== rtl/fpec_ram.sv =====
`timescale 1ns / 1ps

module fpec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fpec_queue.sv =====
`timescale 1ns / 1ps

module fpec_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fpec_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output logic                full,
    output fpec_pkg::qhead_t    head
);

    localparam int DEPTH = fpec_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    fpec_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_pop;

    assign do_pop = pop && (count_reg != '0);
    assign full   = (count_reg == CW'(DEPTH));

    // Wrap pointers at the depth, which need not be a power of two.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];

endmodule

// ===== rtl/fpec_front.sv =====
`timescale 1ns / 1ps

module fpec_front (
    input  logic           start,
    input  logic [2:0]     func,
    input  logic [19:0]    addr,
    input  logic [31:0]    data,
    input  logic           q_full,
    input  logic           clearing,
    output logic           busy,
    output logic           push,
    output fpec_pkg::cmd_t cmd
);

    // Hold off new beats while the queue is full or the array is being cleared.
    assign busy = q_full || clearing;
    assign push = start && !busy;

    // Classify the beat: decode the op, pre-compare the keys, check alignment.
    assign cmd.op      = fpec_pkg::op_t'(func);
    assign cmd.aligned = (addr[1:0] == 2'b00);
    assign cmd.key_one = (data == fpec_pkg::KEY_ONE);
    assign cmd.key_two = (data == fpec_pkg::KEY_TWO);
    assign cmd.word    = addr[19:2];
    assign cmd.data    = data;

endmodule

// ===== rtl/fpec_back.sv =====
`timescale 1ns / 1ps

module fpec_back #(
    parameter int BANK_ADDR_BITS = 17,
    parameter int PAGE_WORDS     = 512
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             bank_swap,
    input  fpec_pkg::qhead_t head,
    output logic             pop,
    output logic             clearing,
    output logic             done,
    output logic [31:0]      read_data,
    output logic [31:0]      status_now
);

    localparam int BW = BANK_ADDR_BITS;
    localparam int AW = BANK_ADDR_BITS + 1;

    fpec_pkg::state_t state_reg, state_next;
    fpec_pkg::cmd_t   cmd_reg, cmd_next;

    logic [31:0]   ctrl_reg, ctrl_next;
    logic [31:0]   stat_reg, stat_next;
    logic          key_reg, key_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] first_reg, first_next;

    logic          walk_bank_reg, walk_bank_next;
    logic [BW-1:0] walk_addr_reg, walk_addr_next;
    logic [BW-1:0] walk_left_reg, walk_left_next;
    logic          pend_b0_reg, pend_b0_next;
    logic          pend_b1_reg, pend_b1_next;
    logic          walk_emit_reg, walk_emit_next;

    logic          done_reg, done_next;
    logic [31:0]   rd_reg, rd_next;
    logic [31:0]   sout_reg, sout_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;

    logic [AW-1:0] logical, phys, first_inc;
    logic [31:0]   page_prod;
    logic [BW-1:0] page_base;
    logic          erase_start;
    logic          walk_last;
    logic          prog_bad;
    logic          emit;

    assign logical   = cmd_reg.word[AW-1:0];
    assign phys      = logical ^ {bank_swap, {BW{1'b0}}};
    assign first_inc = first_reg + AW'(1);
    assign page_prod = 32'(cmd_reg.data[fpec_pkg::CR_PNB_MSB:fpec_pkg::CR_PNB_LSB])
                       * 32'(PAGE_WORDS);
    assign page_base = page_prod[BW-1:0];
    assign walk_last = (walk_left_reg == '0);

    assign erase_start = (cmd_reg.op == fpec_pkg::OP_WR_CR)
                         && !cmd_reg.data[fpec_pkg::CR_LOCK_BIT]
                         && !ctrl_reg[fpec_pkg::CR_LOCK_BIT]
                         && cmd_reg.data[fpec_pkg::CR_STRT_BIT]
                         && !cmd_reg.data[fpec_pkg::CR_PG_BIT]
                         && (cmd_reg.data[fpec_pkg::CR_PER_BIT]
                             || cmd_reg.data[fpec_pkg::CR_MER1_BIT]
                             || cmd_reg.data[fpec_pkg::CR_MER2_BIT]);

    assign prog_bad = ctrl_reg[fpec_pkg::CR_LOCK_BIT] || !cmd_reg.aligned
                      || !ctrl_reg[fpec_pkg::CR_PG_BIT]
                      || (pend_reg && (first_inc != logical))
                      || ((ram_rdata != '0) && (ram_rdata != fpec_pkg::ERASED_WORD));

    fpec_ram #(
        .WIDTH (32),
        .DEPTH (2 ** AW)
    ) u_array (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (phys),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpec_pkg::S_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = fpec_pkg::S_EXEC;
                end
            end
            fpec_pkg::S_EXEC:
            begin
                if ((cmd_reg.op == fpec_pkg::OP_PROG) || (cmd_reg.op == fpec_pkg::OP_RD_WORD))
                begin
                    state_next = fpec_pkg::S_MEM;
                end
                else if (erase_start)
                begin
                    state_next = fpec_pkg::S_ERASE;
                end
                else
                begin
                    state_next = fpec_pkg::S_IDLE;
                end
            end
            fpec_pkg::S_MEM:
            begin
                state_next = fpec_pkg::S_IDLE;
            end
            fpec_pkg::S_ERASE:
            begin
                if (walk_last && !pend_b0_reg && !pend_b1_reg)
                begin
                    state_next = fpec_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fpec_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        ctrl_next      = ctrl_reg;
        stat_next      = stat_reg;
        key_next       = key_reg;
        pend_next      = pend_reg;
        first_next     = first_reg;
        walk_bank_next = walk_bank_reg;
        walk_addr_next = walk_addr_reg;
        walk_left_next = walk_left_reg;
        pend_b0_next   = pend_b0_reg;
        pend_b1_next   = pend_b1_reg;
        walk_emit_next = walk_emit_reg;
        rd_next        = rd_reg;
        sout_next      = sout_reg;
        done_next      = 1'b0;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = phys;
        ram_wdata      = cmd_reg.data;
        emit           = 1'b0;

        case (state_reg)
            fpec_pkg::S_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head.cmd;
                end
            end
            fpec_pkg::S_EXEC:
            begin
                rd_next = '0;
                case (cmd_reg.op)
                    fpec_pkg::OP_RD_SR:
                    begin
                        rd_next = stat_reg;
                        emit    = 1'b1;
                    end
                    fpec_pkg::OP_RD_CR:
                    begin
                        rd_next = ctrl_reg;
                        emit    = 1'b1;
                    end
                    fpec_pkg::OP_WR_SR:
                    begin
                        stat_next = stat_reg & ~cmd_reg.data;
                        if (cmd_reg.data[fpec_pkg::SR_BSY_BIT])
                        begin
                            ctrl_next[fpec_pkg::CR_STRT_BIT] = 1'b0;
                        end
                        emit = 1'b1;
                    end
                    fpec_pkg::OP_WR_CR:
                    begin
                        if (cmd_reg.data[fpec_pkg::CR_LOCK_BIT])
                        begin
                            ctrl_next[fpec_pkg::CR_LOCK_BIT] = 1'b1;
                            key_next = 1'b0;
                            emit     = 1'b1;
                        end
                        else if (ctrl_reg[fpec_pkg::CR_LOCK_BIT])
                        begin
                            if (cmd_reg.data[fpec_pkg::CR_STRT_BIT])
                            begin
                                stat_next[fpec_pkg::SR_PROGERR_BIT] = 1'b1;
                            end
                            emit = 1'b1;
                        end
                        else
                        begin
                            ctrl_next = cmd_reg.data;
                            if (cmd_reg.data[fpec_pkg::CR_STRT_BIT])
                            begin
                                if (cmd_reg.data[fpec_pkg::CR_PG_BIT])
                                begin
                                    stat_next[fpec_pkg::SR_BSY_BIT] = 1'b1;
                                end
                                else
                                begin
                                    stat_next[fpec_pkg::SR_EOP_BIT] = 1'b1;
                                end
                            end
                            emit = !erase_start;
                        end
                        // Queue the walks: page first, then whole banks.
                        if (erase_start)
                        begin
                            walk_emit_next = 1'b1;
                            if (cmd_reg.data[fpec_pkg::CR_PER_BIT])
                            begin
                                walk_bank_next = cmd_reg.data[fpec_pkg::CR_BKER_BIT];
                                walk_addr_next = page_base;
                                walk_left_next = BW'(PAGE_WORDS - 1);
                                pend_b0_next   = cmd_reg.data[fpec_pkg::CR_MER1_BIT];
                                pend_b1_next   = cmd_reg.data[fpec_pkg::CR_MER2_BIT];
                            end
                            else if (cmd_reg.data[fpec_pkg::CR_MER1_BIT])
                            begin
                                walk_bank_next = 1'b0;
                                walk_addr_next = '0;
                                walk_left_next = '1;
                                pend_b0_next   = 1'b0;
                                pend_b1_next   = cmd_reg.data[fpec_pkg::CR_MER2_BIT];
                            end
                            else
                            begin
                                walk_bank_next = 1'b1;
                                walk_addr_next = '0;
                                walk_left_next = '1;
                                pend_b0_next   = 1'b0;
                                pend_b1_next   = 1'b0;
                            end
                        end
                    end
                    fpec_pkg::OP_KEY:
                    begin
                        if (!key_reg && cmd_reg.key_one)
                        begin
                            key_next = 1'b1;
                        end
                        else if (key_reg && cmd_reg.key_two)
                        begin
                            key_next = 1'b0;
                            ctrl_next[fpec_pkg::CR_LOCK_BIT] = 1'b0;
                        end
                        else
                        begin
                            key_next = 1'b0;
                        end
                        emit = 1'b1;
                    end
                    fpec_pkg::OP_PROG, fpec_pkg::OP_RD_WORD:
                    begin
                        // Array read is in flight; finish next cycle.
                        emit = 1'b0;
                    end
                    default:
                    begin
                        emit = 1'b1;
                    end
                endcase
            end
            fpec_pkg::S_MEM:
            begin
                rd_next = '0;
                emit    = 1'b1;
                if (cmd_reg.op == fpec_pkg::OP_RD_WORD)
                begin
                    rd_next = ram_rdata;
                end
                else if (prog_bad)
                begin
                    stat_next[fpec_pkg::SR_BSY_BIT]     = 1'b0;
                    stat_next[fpec_pkg::SR_PROGERR_BIT] = 1'b1;
                end
                else
                begin
                    ram_we = 1'b1;
                    if (!pend_reg)
                    begin
                        pend_next  = 1'b1;
                        first_next = logical;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        stat_next[fpec_pkg::SR_BSY_BIT] = 1'b0;
                        stat_next[fpec_pkg::SR_EOP_BIT] = 1'b1;
                    end
                end
            end
            fpec_pkg::S_ERASE:
            begin
                ram_we         = 1'b1;
                ram_waddr      = {walk_bank_reg, walk_addr_reg};
                ram_wdata      = fpec_pkg::ERASED_WORD;
                walk_addr_next = walk_addr_reg + BW'(1);
                walk_left_next = walk_left_reg - BW'(1);
                if (walk_last)
                begin
                    if (pend_b0_reg)
                    begin
                        walk_bank_next = 1'b0;
                        walk_addr_next = '0;
                        walk_left_next = '1;
                        pend_b0_next   = 1'b0;
                    end
                    else if (pend_b1_reg)
                    begin
                        walk_bank_next = 1'b1;
                        walk_addr_next = '0;
                        walk_left_next = '1;
                        pend_b1_next   = 1'b0;
                    end
                    else
                    begin
                        rd_next = '0;
                        emit    = walk_emit_reg;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (emit)
        begin
            done_next = 1'b1;
            sout_next = stat_next;
        end
    end

    // Reset starts a clearing walk over both banks with no result at its end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpec_pkg::S_ERASE;
            ctrl_reg      <= fpec_pkg::CTRL_RESET;
            stat_reg      <= '0;
            key_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            first_reg     <= '0;
            walk_bank_reg <= 1'b0;
            walk_addr_reg <= '0;
            walk_left_reg <= '1;
            pend_b0_reg   <= 1'b0;
            pend_b1_reg   <= 1'b1;
            walk_emit_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctrl_reg      <= ctrl_next;
            stat_reg      <= stat_next;
            key_reg       <= key_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            walk_bank_reg <= walk_bank_next;
            walk_addr_reg <= walk_addr_next;
            walk_left_reg <= walk_left_next;
            pend_b0_reg   <= pend_b0_next;
            pend_b1_reg   <= pend_b1_next;
            walk_emit_reg <= walk_emit_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        rd_reg   <= rd_next;
        sout_reg <= sout_next;
    end

    assign clearing   = (state_reg == fpec_pkg::S_ERASE) && !walk_emit_reg;
    assign done       = done_reg;
    assign read_data  = rd_reg;
    assign status_now = sout_reg;

endmodule

// ===== rtl/fpec_checker.sv =====
`timescale 1ns / 1ps
`include "flash_program_erase_controller_assert.svh"

module fpec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        done,
    input logic        psel,
    input logic        pwrite,
    input logic [31:0] prdata
);

    // Every command returns the back end to idle before the next runs, so results never abut.
    `FPEC_ASSERT_NEXT(a_done_spaced, done, !done)
    // Reset parks the block in its clearing pass: busy, no results.
    `FPEC_ASSERT_RAW(a_reset_quiet, !rst_n, busy && !done)
    // The clearing pass is still running right after reset is released.
    `FPEC_ASSERT_RAW(a_clear_after_reset, $rose(rst_n), busy)
    // Only one configuration bit exists.
    `FPEC_ASSERT_IMPL(a_prdata_narrow, psel && !pwrite, prdata[31:1] == 31'd0)

endmodule

bind flash_program_erase_controller fpec_checker u_fpec_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .done   (done),
    .psel   (psel),
    .pwrite (pwrite),
    .prdata (prdata)
);

// ===== test/flash_tb_pkg.sv =====
`timescale 1ns / 1ps

package flash_tb_pkg;
    import fpec_pkg::*;

    localparam int BANK_ADDR_BITS = 17;
    localparam int PAGE_WORDS     = 512;
    localparam int BANK_WORDS     = 1 << BANK_ADDR_BITS;
    localparam int ALL_WORDS      = 2 * BANK_WORDS;

    typedef struct {
        logic [31:0] read_data;
        logic [31:0] status_now;
    } flash_reply_t;

    class flash_scoreboard;
        logic                  swap_banks;
        logic [31:0]           control_reg;
        logic [31:0]           status_reg;
        logic                  key_half;
        logic                  pair_open;
        logic [WORD_IDX_W-1:0] pair_word;
        bit   [31:0]           flash_words [ALL_WORDS];
        flash_reply_t          replies_due [$];
        int unsigned           mismatches;

        function new();
            swap_banks  = 1'b0;
            control_reg = CTRL_RESET;
            status_reg  = '0;
            key_half    = 1'b0;
            pair_open   = 1'b0;
            pair_word   = '0;
            mismatches  = 0;
            foreach (flash_words[i])
                flash_words[i] = ERASED_WORD;
        endfunction

        function void set_swap(logic value);
            swap_banks = value;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function logic [WORD_IDX_W-1:0] phys_word(logic [WORD_IDX_W-1:0] w);
            logic [WORD_IDX_W-1:0] p;
            p = w;
            p[BANK_ADDR_BITS] = p[BANK_ADDR_BITS] ^ swap_banks;
            return p;
        endfunction

        function void write_control(logic [31:0] v);
            int unsigned base;
            int unsigned page;
            int unsigned i;
            if (v[CR_LOCK_BIT])
            begin
                control_reg[CR_LOCK_BIT] = 1'b1;
                key_half = 1'b0;
                return;
            end
            if (control_reg[CR_LOCK_BIT])
            begin
                if (v[CR_STRT_BIT])
                    status_reg[SR_PROGERR_BIT] = 1'b1;
                return;
            end
            control_reg = v;
            if (!v[CR_STRT_BIT])
                return;
            if (v[CR_PG_BIT])
            begin
                status_reg[SR_BSY_BIT] = 1'b1;
                return;
            end
            if (v[CR_PER_BIT])
            begin
                base = v[CR_BKER_BIT] ? BANK_WORDS : 0;
                page = v[CR_PNB_MSB:CR_PNB_LSB];
                for (i = 0; i < PAGE_WORDS; i++)
                    flash_words[base + ((page * PAGE_WORDS + i) & (BANK_WORDS - 1))] = ERASED_WORD;
            end
            if (v[CR_MER1_BIT])
                for (i = 0; i < BANK_WORDS; i++)
                    flash_words[i] = ERASED_WORD;
            if (v[CR_MER2_BIT])
                for (i = 0; i < BANK_WORDS; i++)
                    flash_words[BANK_WORDS + i] = ERASED_WORD;
            status_reg[SR_EOP_BIT] = 1'b1;
        endfunction

        function void program_word(logic [19:0] a, logic [31:0] d);
            logic [WORD_IDX_W-1:0] w;
            logic [WORD_IDX_W-1:0] p;
            logic [WORD_IDX_W-1:0] follow;
            logic [31:0]           cur;
            w      = a[19:2];
            p      = phys_word(w);
            cur    = flash_words[p];
            follow = pair_word + 1'b1;
            if (control_reg[CR_LOCK_BIT] || a[1:0] != 2'b00 || !control_reg[CR_PG_BIT]
                || (pair_open && follow != w) || (cur != 32'd0 && cur != ERASED_WORD))
            begin
                status_reg[SR_BSY_BIT]     = 1'b0;
                status_reg[SR_PROGERR_BIT] = 1'b1;
                return;
            end
            if (!pair_open)
            begin
                pair_open = 1'b1;
                pair_word = w;
            end
            else
            begin
                pair_open = 1'b0;
                status_reg[SR_BSY_BIT] = 1'b0;
                status_reg[SR_EOP_BIT] = 1'b1;
            end
            flash_words[p] = d;
        endfunction

        // Apply one accepted beat and queue the reply it must produce.
        function void note_access(op_t op, logic [19:0] a, logic [31:0] d);
            flash_reply_t r;
            r.read_data = '0;
            case (op)
                OP_RD_SR:   r.read_data = status_reg;
                OP_RD_CR:   r.read_data = control_reg;
                OP_WR_SR:
                begin
                    status_reg = status_reg & ~d;
                    if (d[SR_BSY_BIT])
                        control_reg[CR_STRT_BIT] = 1'b0;
                end
                OP_WR_CR:   write_control(d);
                OP_KEY:
                begin
                    if (!key_half && d == KEY_ONE)
                        key_half = 1'b1;
                    else if (key_half && d == KEY_TWO)
                    begin
                        key_half = 1'b0;
                        control_reg[CR_LOCK_BIT] = 1'b0;
                    end
                    else
                        key_half = 1'b0;
                end
                OP_PROG:    program_word(a, d);
                OP_RD_WORD: r.read_data = flash_words[phys_word(a[19:2])];
                default:    ;
            endcase
            r.status_now = status_reg;
            replies_due.push_back(r);
        endfunction

        function void check_result(logic [31:0] rd, logic [31:0] st);
            flash_reply_t r;
            if (replies_due.size() == 0)
            begin
                $error("unexpected reply: read_data %h status_now %h", rd, st);
                mismatches++;
                return;
            end
            r = replies_due.pop_front();
            if (rd !== r.read_data)
            begin
                $error("read_data expected %h actual %h", r.read_data, rd);
                mismatches++;
            end
            if (st !== r.status_now)
            begin
                $error("status_now expected %h actual %h", r.status_now, st);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import fpec_pkg::*;
    import flash_tb_pkg::*;

    // Cycles with no beat in either direction before the run is declared hung.
    // The longest silence this bench can cause is the clearing pass after reset over both banks.
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int PHASE_BEATS    = 400;

    localparam logic [31:0] CR_PG   = 32'd1 << CR_PG_BIT;
    localparam logic [31:0] CR_PER  = 32'd1 << CR_PER_BIT;
    localparam logic [31:0] CR_MER1 = 32'd1 << CR_MER1_BIT;
    localparam logic [31:0] CR_BKER = 32'd1 << CR_BKER_BIT;
    localparam logic [31:0] CR_MER2 = 32'd1 << CR_MER2_BIT;
    localparam logic [31:0] CR_STRT = 32'd1 << CR_STRT_BIT;
    localparam logic [31:0] CR_LOCK = 32'd1 << CR_LOCK_BIT;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  func = OP_NONE;
    logic [19:0] addr = '0;
    logic [31:0] data = '0;
    logic        done;
    logic [31:0] read_data;
    logic [31:0] status_now;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    flash_scoreboard board;

    // Mirrors the value last scheduled on start, so start is never assigned twice
    // in one time step.
    logic        sender_on = 1'b0;
    int unsigned burst_left = 0;
    int unsigned beats_sent = 0;
    int unsigned idle_cycles = 0;

    flash_program_erase_controller #(
        .BANK_ADDR_BITS(BANK_ADDR_BITS),
        .PAGE_WORDS    (PAGE_WORDS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .addr      (addr),
        .data      (data),
        .done      (done),
        .read_data (read_data),
        .status_now(status_now),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Check every reply strobe against the oldest predicted reply.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(read_data, status_now);
    end

    // Count cycles that move no beat at all; bail out if the block hangs.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Drop start and hold until every predicted reply has been seen. Sample at the
    // falling edge so the check never races the reply monitor, then realign to a
    // rising edge for the next drive.
    task automatic drain_results();
        if (sender_on)
        begin
            start <= 1'b0;
            sender_on = 1'b0;
        end
        while (board.pending() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Decide what the sender does after a beat: keep streaming within the burst,
    // or idle for a random gap, and once in a while wait for the block to empty.
    task automatic pace_sender();
        if (burst_left != 0)
            burst_left--;
        else
        begin
            if ($urandom_range(0, 149) == 0)
                drain_results();
            else
            begin
                start <= 1'b0;
                sender_on = 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Present one command beat, hold it until busy lets it through, log it with
    // the predictor, then pace the next one.
    task automatic send_beat(input op_t op, input logic [19:0] a, input logic [31:0] d);
        start <= 1'b1;
        sender_on = 1'b1;
        func  <= op;
        addr  <= a;
        data  <= d;
        do
            @(posedge clk);
        while (busy);
        board.note_access(op, a, d);
        if (op != OP_NONE)
            beats_sent++;
        pace_sender();
    endtask

    // Write bank_swap over APB, then read it back. psel stays high across the
    // write and the read so it is assigned only once per edge.
    task automatic set_bank_swap(input logic value);
        logic [31:0] v;
        v = {31'd0, value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BANK_SWAP, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_swap(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== v)
        begin
            $error("bank_swap expected %h actual %h", v, prdata);
            board.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Word index biased toward a few hot spots: the bottom of the array, the
    // seam between the banks and the very top, where pairs wrap to zero.
    function automatic logic [WORD_IDX_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return WORD_IDX_W'($urandom_range(0, 63));
            1:       return WORD_IDX_W'(BANK_WORDS - 32 + $urandom_range(0, 63));
            2:       return WORD_IDX_W'(ALL_WORDS - 32 + $urandom_range(0, 31));
            default: return WORD_IDX_W'($urandom);
        endcase
    endfunction

    // Zero and erased values keep a word programmable again.
    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return ERASED_WORD;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random_phase(input int unsigned quota);
        int unsigned           stop_at;
        int unsigned           pick;
        logic [WORD_IDX_W-1:0] w;
        logic [1:0]            lo;
        logic [31:0]           d;
        op_t                   op;
        stop_at = beats_sent + quota;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                // Unlock, now and then with a bad second key.
                send_beat(OP_KEY, 20'($urandom), KEY_ONE);
                send_beat(OP_KEY, 20'($urandom),
                          ($urandom_range(0, 4) == 0) ? 32'($urandom) : KEY_TWO);
            end
            else if (pick < 22)
            begin
                // Arm programming; mostly with the start bit.
                d = $urandom;
                d = (d & ~CR_LOCK) | CR_PG;
                d[CR_STRT_BIT] = ($urandom_range(0, 9) != 0);
                send_beat(OP_WR_CR, 20'($urandom), d);
            end
            else if (pick < 50)
            begin
                // Program a pair; sometimes misaligned, broken or left half done.
                w  = pick_word();
                lo = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
                send_beat(OP_PROG, {w, lo}, pick_data());
                if ($urandom_range(0, 9) != 0)
                begin
                    w  = ($urandom_range(0, 6) == 0) ? pick_word() : w + 1'b1;
                    lo = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
                    send_beat(OP_PROG, {w, lo}, pick_data());
                end
            end
            else if (pick < 62)
            begin
                repeat ($urandom_range(1, 3))
                    send_beat(OP_RD_WORD, {pick_word(), 2'($urandom)}, $urandom);
            end
            else if (pick < 70)
                send_beat(OP_WR_SR, 20'($urandom),
                          $urandom_range(0, 1) ? 32'($urandom) : ERASED_WORD);
            else if (pick < 73)
                send_beat(OP_WR_CR, 20'($urandom), $urandom & ~(CR_LOCK | CR_STRT));
            else if (pick < 77)
            begin
                // Page erase, mostly on pages that hold the hot spots.
                case ($urandom_range(0, 2))
                    0:       d = 32'd0;
                    1:       d = 32'd255;
                    default: d = $urandom_range(0, 255);
                endcase
                d = (d << CR_PNB_LSB) | CR_STRT | CR_PER;
                if ($urandom_range(0, 1))
                    d = d | CR_BKER;
                send_beat(OP_WR_CR, 20'($urandom), d);
            end
            else if (pick < 80)
                send_beat(OP_WR_CR, 20'($urandom), $urandom | CR_LOCK);
            else if (pick < 88)
                send_beat($urandom_range(0, 1) ? OP_RD_SR : OP_RD_CR, 20'($urandom), $urandom);
            else
            begin
                // Raw noise; keep mass erases out, they walk a whole bank each.
                repeat ($urandom_range(1, 3))
                begin
                    op = op_t'($urandom_range(0, 7));
                    d  = $urandom;
                    if (op == OP_WR_CR && d[CR_STRT_BIT])
                        d = d & ~(CR_MER1 | CR_MER2);
                    send_beat(op, 20'($urandom), d);
                end
            end
        end
    endtask

    initial
    begin
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // Hold off configuration until the clearing pass is over.
        do
            @(posedge clk);
        while (busy);
        set_bank_swap(1'b0);

        // Directed: lock rules, key sequence, program rules, erases.
        send_beat(OP_RD_CR,   20'h00000, 32'h0);
        send_beat(OP_WR_CR,   20'h00000, CR_STRT | CR_MER1);   // start while locked
        send_beat(OP_PROG,    20'h00000, 32'h0);               // program while locked
        send_beat(OP_RD_SR,   20'h00000, 32'h0);
        send_beat(OP_KEY,     20'h00000, KEY_ONE);
        send_beat(OP_KEY,     20'h00000, 32'h0);               // wrong key restarts
        send_beat(OP_KEY,     20'h00000, KEY_TWO);             // second key out of order
        send_beat(OP_KEY,     20'h00000, KEY_ONE);
        send_beat(OP_KEY,     20'h00000, KEY_TWO);             // unlocked
        send_beat(OP_WR_SR,   20'h00000, ERASED_WORD);
        send_beat(OP_WR_CR,   20'h00000, CR_PG | CR_STRT);
        send_beat(OP_RD_CR,   20'h00000, 32'h0);
        send_beat(OP_PROG,    20'h00000, 32'h0);               // first word of pair
        send_beat(OP_PROG,    20'h0000C, 32'h1);               // not the next word
        send_beat(OP_PROG,    20'h00005, 32'h2);               // misaligned
        send_beat(OP_PROG,    20'h00004, 32'h1234_5678);       // completes the pair
        send_beat(OP_PROG,    20'h00004, 32'h0);               // target neither zero nor erased
        send_beat(OP_RD_WORD, 20'h00007, 32'h0);
        send_beat(OP_PROG,    20'hFFFFC, 32'h0);               // last word of the array
        send_beat(OP_PROG,    20'h00000, 32'hA5A5_5A5A);       // wraps to word zero
        send_beat(OP_WR_CR,   20'h00000, CR_STRT | CR_PER | CR_BKER | (32'hFF << CR_PNB_LSB));
        send_beat(OP_RD_WORD, 20'hFFFFC, 32'h0);
        send_beat(OP_WR_CR,   20'h00000, CR_STRT | CR_PER | CR_MER1);
        send_beat(OP_WR_CR,   20'h00000, CR_STRT | CR_MER2);
        send_beat(OP_WR_CR,   20'h00000, ERASED_WORD);         // lock wins over every other bit
        send_beat(OP_NONE,    20'hFFFFF, ERASED_WORD);
        send_beat(OP_RD_WORD, 20'hFFFFF, 32'h0);

        // Random phases, flipping the bank mapping between them.
        for (int phase = 0; phase < 4; phase++)
        begin
            drain_results();
            set_bank_swap((phase % 2) == 0);
            run_random_phase(PHASE_BEATS);
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fpec_pkg.sv
rtl/fpec_ram.sv
rtl/fpec_queue.sv
rtl/fpec_front.sv
rtl/fpec_back.sv
rtl/flash_program_erase_controller.sv
rtl/fpec_checker.sv
test/flash_tb_pkg.sv
test/tb_top.sv
